// ----- rtl/core/esc_pkg.sv -----
// shared constants, register indexes and helpers for the environment sensor compensation block
package esc_pkg;

    localparam int DATA_W = 64;
    localparam int VAL_W  = 24;
    localparam int RAW_W  = 20;

    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_HUM   = 2'd2;

    localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
    localparam logic [2:0] REG_PRESS_CAL_LO   = 3'd1;
    localparam logic [2:0] REG_PRESS_CAL_HI   = 3'd2;
    localparam logic [2:0] REG_PRESS_CAL_NINE = 3'd3;
    localparam logic [2:0] REG_HUM_CAL_LO     = 3'd4;
    localparam logic [2:0] REG_HUM_CAL_HI     = 3'd5;

    localparam logic [63:0] FINE_OFFSET_P = 64'd128000;
    localparam logic [63:0] PRESS_BASE    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE   = 64'd3125;
    localparam logic [31:0] FINE_OFFSET_H = 32'd76800;
    localparam logic [31:0] HUM_LIMIT     = 32'd419430400;
    localparam logic [31:0] HUM_ROUND_A   = 32'd16384;
    localparam logic [31:0] HUM_OFFSET_B  = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_B   = 32'd8192;
    localparam logic [31:0] HUM_OFFSET_Z  = 32'd32768;

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [23:0] sat24(input logic [63:0] x);
        logic [23:0] r;
        if (x[63] && !(&x[62:23])) begin
            r = 24'h800000;
        end else if (!x[63] && (|x[62:23])) begin
            r = 24'h7FFFFF;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/esc_mul.sv -----
// shared 64-bit wrapping multiplier, one 64x16 partial product per cycle
module esc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [79:0] pp;

    assign pp = {16'b0, a_reg} * {64'b0, b_reg[15:0]};

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp[63:0];
            a_next   = {a_reg[47:0], 16'b0};
            b_next   = {16'b0, b_reg[63:16]};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/core/esc_div.sv -----
// signed 64-bit radix-2 restoring divider, truncating toward zero
module esc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        qbit;
    logic [63:0] q_fin;

    always_comb begin
        rem_sh = {rem_reg, dvd_reg[63]};
        diff   = rem_sh - {1'b0, dvs_reg};
        qbit   = !diff[64];
        q_fin  = {dvd_reg[62:0], qbit};
    end

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = num[63] ? 64'd0 - num : num;
            dvs_next  = den[63] ? 64'd0 - den : den;
            rem_next  = '0;
            cnt_next  = '0;
            neg_next  = num[63] ^ den[63];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[63:0] : rem_sh[63:0];
            dvd_next = q_fin;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                q_next    = neg_reg ? 64'd0 - q_fin : q_fin;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ----- rtl/core/environment_sensor_compensation.sv -----
// top level: sequencer for temperature, pressure and humidity compensation
// One raw sample is taken at a time and compensated by a small sequencer around
// one shared 64-bit multiplier and, for pressure, a radix-2 divider. The next
// sample is taken once the previous result sits in the output register.
// Temperature samples update the kept fine temperature used by pressure and
// humidity; a zero pressure divisor returns 0 with the error flag set.
// Calibration is written through the plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce.
module environment_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_sample [19:0], zero fill
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value [23:0]
    output logic [2:0]  m_tuser,   // result_kind [1:0], divide_error [2]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MW   = 5'd1;
    localparam logic [4:0] S_DW   = 5'd2;
    localparam logic [4:0] S_FIN  = 5'd3;
    localparam logic [4:0] S_T0   = 5'd4;
    localparam logic [4:0] S_T1   = 5'd5;
    localparam logic [4:0] S_T2   = 5'd6;
    localparam logic [4:0] S_T3   = 5'd7;
    localparam logic [4:0] S_P0   = 5'd8;
    localparam logic [4:0] S_P1   = 5'd9;
    localparam logic [4:0] S_P2   = 5'd10;
    localparam logic [4:0] S_P3   = 5'd11;
    localparam logic [4:0] S_P4   = 5'd12;
    localparam logic [4:0] S_P5   = 5'd13;
    localparam logic [4:0] S_P6   = 5'd14;
    localparam logic [4:0] S_P7   = 5'd15;
    localparam logic [4:0] S_P8   = 5'd16;
    localparam logic [4:0] S_P9   = 5'd17;
    localparam logic [4:0] S_P10  = 5'd18;
    localparam logic [4:0] S_P11  = 5'd19;
    localparam logic [4:0] S_H0   = 5'd20;
    localparam logic [4:0] S_H1   = 5'd21;
    localparam logic [4:0] S_H2   = 5'd22;
    localparam logic [4:0] S_H3   = 5'd23;
    localparam logic [4:0] S_H4   = 5'd24;
    localparam logic [4:0] S_H5   = 5'd25;
    localparam logic [4:0] S_H6   = 5'd26;
    localparam logic [4:0] S_H7   = 5'd27;
    localparam logic [4:0] S_H8   = 5'd28;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_nine_reg;
    logic [39:0] hum_lo_reg;
    logic [23:0] hum_hi_reg;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;
    logic [1:0]  kind_reg, kind_next;
    logic [19:0] raw_reg, raw_next;
    logic [31:0] fine_reg, fine_next;
    logic [63:0] ra_reg, ra_next;
    logic [63:0] rb_reg, rb_next;
    logic [63:0] rc_reg, rc_next;
    logic [63:0] rd_reg, rd_next;
    logic [23:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic        ovalid_reg, ovalid_next;
    logic [23:0] oval_reg, oval_next;
    logic [1:0]  okind_reg, okind_next;
    logic        oerr_reg, oerr_next;

    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_p;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;

    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h6;
    logic [11:0] h4, h5;
    logic [31:0] p32;
    logic [63:0] w64, x64;
    logic [31:0] w32, x32;

    assign t1 = {48'b0, temp_cal_reg[15:0]};
    assign t2 = esc_pkg::sx16(temp_cal_reg[31:16]);
    assign t3 = esc_pkg::sx16(temp_cal_reg[47:32]);
    assign p1 = {48'b0, press_lo_reg[15:0]};
    assign p2 = esc_pkg::sx16(press_lo_reg[31:16]);
    assign p3 = esc_pkg::sx16(press_lo_reg[47:32]);
    assign p4 = esc_pkg::sx16(press_lo_reg[63:48]);
    assign p5 = esc_pkg::sx16(press_hi_reg[15:0]);
    assign p6 = esc_pkg::sx16(press_hi_reg[31:16]);
    assign p7 = esc_pkg::sx16(press_hi_reg[47:32]);
    assign p8 = esc_pkg::sx16(press_hi_reg[63:48]);
    assign p9 = esc_pkg::sx16(press_nine_reg);
    assign h1 = {24'b0, hum_lo_reg[7:0]};
    assign h2 = {{16{hum_lo_reg[23]}}, hum_lo_reg[23:8]};
    assign h3 = {24'b0, hum_lo_reg[31:24]};
    assign h6 = {{24{hum_lo_reg[39]}}, hum_lo_reg[39:32]};
    assign h4 = hum_hi_reg[11:0];
    assign h5 = hum_hi_reg[23:12];
    assign p32 = mul_p[31:0];

    esc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    esc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mul_p),
        .den     (rb_reg),
        .done    (div_done),
        .quo     (div_q)
    );

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        kind_next   = kind_reg;
        raw_next    = raw_reg;
        fine_next   = fine_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rc_next     = rc_reg;
        rd_next     = rd_reg;
        res_next    = res_reg;
        err_next    = err_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        okind_next  = okind_reg;
        oerr_next   = oerr_reg;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        w64         = '0;
        x64         = '0;
        w32         = '0;
        x32         = '0;

        if (m_tvalid && m_tready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    raw_next  = s_tdata[19:0];
                    res_next  = '0;
                    err_next  = 1'b0;
                    unique case (s_tuser)
                        esc_pkg::KIND_TEMP:  state_next = S_T0;
                        esc_pkg::KIND_PRESS: state_next = S_P0;
                        esc_pkg::KIND_HUM:   state_next = S_H0;
                        default:             state_next = S_FIN;
                    endcase
                end
            end
            S_MW: begin
                if (mul_done) begin
                    state_next = ret_reg;
                end
            end
            S_DW: begin
                if (div_done) begin
                    state_next = ret_reg;
                end
            end
            S_FIN: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    oval_next   = res_reg;
                    okind_next  = kind_reg;
                    oerr_next   = err_reg;
                    state_next  = S_IDLE;
                end
            end
            // temperature
            S_T0: begin
                mul_start  = 1'b1;
                mul_a      = {47'b0, raw_reg[19:3]} - {t1[62:0], 1'b0};
                mul_b      = t2;
                ret_next   = S_T1;
                state_next = S_MW;
            end
            S_T1: begin
                ra_next    = 64'($signed(mul_p) >>> 11);
                w64        = {48'b0, raw_reg[19:4]} - t1;
                mul_start  = 1'b1;
                mul_a      = w64;
                mul_b      = w64;
                ret_next   = S_T2;
                state_next = S_MW;
            end
            S_T2: begin
                mul_start  = 1'b1;
                mul_a      = 64'($signed(mul_p) >>> 12);
                mul_b      = t3;
                ret_next   = S_T3;
                state_next = S_MW;
            end
            S_T3: begin
                w64        = ra_reg + 64'($signed(mul_p) >>> 14);
                fine_next  = w64[31:0];
                x64        = {w64[61:0], 2'b0} + w64 + 64'd128;
                res_next   = esc_pkg::sat24(64'($signed(x64) >>> 8));
                state_next = S_FIN;
            end
            // pressure
            S_P0: begin
                w64        = esc_pkg::sx32(fine_reg) - esc_pkg::FINE_OFFSET_P;
                ra_next    = w64;
                mul_start  = 1'b1;
                mul_a      = w64;
                mul_b      = w64;
                ret_next   = S_P1;
                state_next = S_MW;
            end
            S_P1: begin
                rb_next    = mul_p;
                mul_start  = 1'b1;
                mul_a      = mul_p;
                mul_b      = p6;
                ret_next   = S_P2;
                state_next = S_MW;
            end
            S_P2: begin
                rc_next    = mul_p;
                mul_start  = 1'b1;
                mul_a      = ra_reg;
                mul_b      = p5;
                ret_next   = S_P3;
                state_next = S_MW;
            end
            S_P3: begin
                rc_next    = rc_reg + {mul_p[46:0], 17'b0} + {p4[28:0], 35'b0};
                mul_start  = 1'b1;
                mul_a      = rb_reg;
                mul_b      = p3;
                ret_next   = S_P4;
                state_next = S_MW;
            end
            S_P4: begin
                rd_next    = 64'($signed(mul_p) >>> 8);
                mul_start  = 1'b1;
                mul_a      = ra_reg;
                mul_b      = p2;
                ret_next   = S_P5;
                state_next = S_MW;
            end
            S_P5: begin
                w64        = rd_reg + {mul_p[51:0], 12'b0};
                mul_start  = 1'b1;
                mul_a      = {16'b0, 1'b1, 47'b0} + w64;
                mul_b      = p1;
                ret_next   = S_P6;
                state_next = S_MW;
            end
            S_P6: begin
                w64 = 64'($signed(mul_p) >>> 33);
                if (w64 == 64'd0) begin
                    res_next   = '0;
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end else begin
                    rb_next    = w64;
                    x64        = esc_pkg::PRESS_BASE - {44'b0, raw_reg};
                    mul_start  = 1'b1;
                    mul_a      = {x64[32:0], 31'b0} - rc_reg;
                    mul_b      = esc_pkg::PRESS_SCALE;
                    ret_next   = S_P7;
                    state_next = S_MW;
                end
            end
            S_P7: begin
                div_start  = 1'b1;
                ret_next   = S_P8;
                state_next = S_DW;
            end
            S_P8: begin
                rd_next    = div_q;
                w64        = 64'($signed(div_q) >>> 13);
                ra_next    = w64;
                mul_start  = 1'b1;
                mul_a      = p9;
                mul_b      = w64;
                ret_next   = S_P9;
                state_next = S_MW;
            end
            S_P9: begin
                mul_start  = 1'b1;
                mul_a      = mul_p;
                mul_b      = ra_reg;
                ret_next   = S_P10;
                state_next = S_MW;
            end
            S_P10: begin
                rc_next    = 64'($signed(mul_p) >>> 25);
                mul_start  = 1'b1;
                mul_a      = p8;
                mul_b      = rd_reg;
                ret_next   = S_P11;
                state_next = S_MW;
            end
            S_P11: begin
                w64        = rd_reg + rc_reg + 64'($signed(mul_p) >>> 19);
                x64        = 64'($signed(w64) >>> 8) + {p7[59:0], 4'b0};
                res_next   = esc_pkg::sat24(64'($signed(x64) >>> 8));
                state_next = S_FIN;
            end
            // humidity
            S_H0: begin
                w32        = fine_reg - esc_pkg::FINE_OFFSET_H;
                ra_next    = {32'b0, w32};
                mul_start  = 1'b1;
                mul_a      = {32'b0, w32};
                mul_b      = {{52{h5[11]}}, h5};
                ret_next   = S_H1;
                state_next = S_MW;
            end
            S_H1: begin
                w32        = {2'b0, raw_reg[15:0], 14'b0} - {h4, 20'b0} - p32
                             + esc_pkg::HUM_ROUND_A;
                rb_next    = {32'b0, 32'($signed(w32) >>> 15)};
                mul_start  = 1'b1;
                mul_a      = ra_reg;
                mul_b      = {32'b0, h6};
                ret_next   = S_H2;
                state_next = S_MW;
            end
            S_H2: begin
                rc_next    = {32'b0, 32'($signed(p32) >>> 10)};
                mul_start  = 1'b1;
                mul_a      = ra_reg;
                mul_b      = {32'b0, h3};
                ret_next   = S_H3;
                state_next = S_MW;
            end
            S_H3: begin
                w32        = 32'($signed(p32) >>> 11) + esc_pkg::HUM_OFFSET_Z;
                mul_start  = 1'b1;
                mul_a      = rc_reg;
                mul_b      = {32'b0, w32};
                ret_next   = S_H4;
                state_next = S_MW;
            end
            S_H4: begin
                w32        = 32'($signed(p32) >>> 10) + esc_pkg::HUM_OFFSET_B;
                mul_start  = 1'b1;
                mul_a      = {32'b0, w32};
                mul_b      = {32'b0, h2};
                ret_next   = S_H5;
                state_next = S_MW;
            end
            S_H5: begin
                w32        = p32 + esc_pkg::HUM_ROUND_B;
                mul_start  = 1'b1;
                mul_a      = rb_reg;
                mul_b      = {32'b0, 32'($signed(w32) >>> 14)};
                ret_next   = S_H6;
                state_next = S_MW;
            end
            S_H6: begin
                rc_next    = {32'b0, p32};
                w32        = 32'($signed(p32) >>> 15);
                mul_start  = 1'b1;
                mul_a      = {32'b0, w32};
                mul_b      = {32'b0, w32};
                ret_next   = S_H7;
                state_next = S_MW;
            end
            S_H7: begin
                mul_start  = 1'b1;
                mul_a      = {32'b0, 32'($signed(p32) >>> 7)};
                mul_b      = {32'b0, h1};
                ret_next   = S_H8;
                state_next = S_MW;
            end
            S_H8: begin
                w32 = rc_reg[31:0] - 32'($signed(p32) >>> 4);
                priority if (w32[31]) begin
                    x32 = '0;
                end else if (w32 > esc_pkg::HUM_LIMIT) begin
                    x32 = esc_pkg::HUM_LIMIT;
                end else begin
                    x32 = w32;
                end
                res_next   = {14'b0, x32[31:22]};
                state_next = S_FIN;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            fine_reg       <= '0;
            ovalid_reg     <= 1'b0;
            temp_cal_reg   <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_nine_reg <= '0;
            hum_lo_reg     <= '0;
            hum_hi_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            fine_reg   <= fine_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    esc_pkg::REG_TEMP_CAL:       temp_cal_reg   <= cfg_wdata[47:0];
                    esc_pkg::REG_PRESS_CAL_LO:   press_lo_reg   <= cfg_wdata;
                    esc_pkg::REG_PRESS_CAL_HI:   press_hi_reg   <= cfg_wdata;
                    esc_pkg::REG_PRESS_CAL_NINE: press_nine_reg <= cfg_wdata[15:0];
                    esc_pkg::REG_HUM_CAL_LO:     hum_lo_reg     <= cfg_wdata[39:0];
                    esc_pkg::REG_HUM_CAL_HI:     hum_hi_reg     <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
        end
        kind_reg  <= kind_next;
        raw_reg   <= raw_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rc_reg    <= rc_next;
        rd_reg    <= rd_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        oval_reg  <= oval_next;
        okind_reg <= okind_next;
        oerr_reg  <= oerr_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oval_reg;
    assign m_tuser  = {oerr_reg, okind_reg};

endmodule

// ----- bench/tb_top.sv -----
// testbench for the environment sensor compensation block: random and directed samples checked
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [2:0] REG_SPARE_A  = 3'd6;
    localparam logic [2:0] REG_SPARE_B  = 3'd7;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         SETTLE       = 200;

    typedef struct {
        logic [1:0]  kind;
        logic [23:0] value;
        logic        div_err;
    } comp_result_t;

    class comp_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_lo, press_hi;
        logic [15:0] press_nine;
        logic [39:0] hum_lo;
        logic [23:0] hum_hi;
        int          fine_temp;
        comp_result_t pending_q[$];
        int          errors;

        function new();
            temp_cal = '0; press_lo = '0; press_hi = '0; press_nine = '0;
            hum_lo = '0; hum_hi = '0; fine_temp = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                esc_pkg::REG_TEMP_CAL:       temp_cal   = data[47:0];
                esc_pkg::REG_PRESS_CAL_LO:   press_lo   = data;
                esc_pkg::REG_PRESS_CAL_HI:   press_hi   = data;
                esc_pkg::REG_PRESS_CAL_NINE: press_nine = data[15:0];
                esc_pkg::REG_HUM_CAL_LO:     hum_lo     = data[39:0];
                esc_pkg::REG_HUM_CAL_HI:     hum_hi     = data[23:0];
                default: ;
            endcase
        endfunction

        function logic [23:0] clamp24(longint x);
            if (x < -64'sd8388608) x = -64'sd8388608;
            else if (x > 64'sd8388607) x = 64'sd8388607;
            return x[23:0];
        endfunction

        function longint div_trunc(longint a, longint b);
            longint unsigned ma, mb, q;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            q = ma / mb;
            return ((a < 0) != (b < 0)) ? -q : q;
        endfunction

        function logic [23:0] comp_temp(logic [19:0] raw);
            longint t1, t2, t3, d3, d4, v1, v2, tf;
            t1 = temp_cal[15:0];
            t2 = $signed(temp_cal[31:16]);
            t3 = $signed(temp_cal[47:32]);
            d3 = longint'(raw >> 3) - t1 * 2;
            d4 = longint'(raw >> 4) - t1;
            v1 = (d3 * t2) >>> 11;
            v2 = (((d4 * d4) >>> 12) * t3) >>> 14;
            tf = v1 + v2;
            fine_temp = tf[31:0];
            return clamp24((tf * 5 + 128) >>> 8);
        endfunction

        function logic [23:0] comp_press(logic [19:0] raw, output logic div_err);
            longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, a;
            p1 = press_lo[15:0];
            p2 = $signed(press_lo[31:16]);
            p3 = $signed(press_lo[47:32]);
            p4 = $signed(press_lo[63:48]);
            p5 = $signed(press_hi[15:0]);
            p6 = $signed(press_hi[31:16]);
            p7 = $signed(press_hi[47:32]);
            p8 = $signed(press_hi[63:48]);
            p9 = $signed(press_nine);
            div_err = 1'b0;
            v1 = longint'(fine_temp) - 128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + v1 * p5 * 131072;
            v2 = v2 + p4 * 64'sd34359738368;
            v1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
            v1 = ((64'sd140737488355328 + v1) * p1) >>> 33;
            if (v1 == 0) begin
                div_err = 1'b1;
                return '0;
            end
            p = 64'sd1048576 - longint'(raw);
            p = div_trunc((p * 64'sd2147483648 - v2) * 3125, v1);
            a = p >>> 13;
            v1 = (p9 * a * a) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + p7 * 16;
            return clamp24(p >>> 8);
        endfunction

        function logic [23:0] comp_hum(logic [19:0] raw);
            int h1, h2, h3, h4, h5, h6, adc, v, a, b, s;
            h1 = hum_lo[7:0];
            h2 = $signed(hum_lo[23:8]);
            h3 = hum_lo[31:24];
            h6 = $signed(hum_lo[39:32]);
            h4 = $signed(hum_hi[11:0]);
            h5 = $signed(hum_hi[23:12]);
            adc = raw[15:0];
            v = fine_temp - 76800;
            a = ((adc << 14) - (h4 << 20) - h5 * v + 16384) >>> 15;
            b = ((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768);
            b = (b >>> 10) + 2097152;
            b = (b * h2 + 8192) >>> 14;
            v = a * b;
            s = v >>> 15;
            v = v - ((((s * s) >>> 7) * h1) >>> 4);
            if (v < 0) v = 0;
            if (v > 419430400) v = 419430400;
            return 24'(v >>> 22);
        endfunction

        function void note_request(logic [1:0] kind, logic [19:0] raw);
            comp_result_t r;
            r.kind = kind;
            r.value = '0;
            r.div_err = 1'b0;
            case (kind)
                esc_pkg::KIND_TEMP:  r.value = comp_temp(raw);
                esc_pkg::KIND_PRESS: r.value = comp_press(raw, r.div_err);
                esc_pkg::KIND_HUM:   r.value = comp_hum(raw);
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [23:0] tdata, logic [2:0] tuser);
            comp_result_t r;
            if (pending_q.size() == 0) begin
                $error("unexpected result kind=%0d value=%0d", tuser[1:0], $signed(tdata));
                errors++;
                return;
            end
            r = pending_q.pop_front();
            if (tuser[1:0] !== r.kind) begin
                $error("result_kind expected %0d actual %0d", r.kind, tuser[1:0]);
                errors++;
            end
            if (tdata !== r.value) begin
                $error("value expected %0d actual %0d", $signed(r.value), $signed(tdata));
                errors++;
            end
            if (tuser[2] !== r.div_err) begin
                $error("divide_error expected %0d actual %0d", r.div_err, tuser[2]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    comp_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int cycles;

    environment_sensor_compensation u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // result side: random stalls, long hold-off on request, checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [1:0] kind, logic [19:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, raw};
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, raw);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // mode 0 typical, 1 all ones, 2 typical with zero P1, 3 jittered, 4 random
    task automatic load_cal(int mode);
        logic [15:0] t[3];
        logic [15:0] p[9];
        logic [7:0]  h1, h3, h6;
        logic [15:0] h2;
        logic [11:0] h4, h5;
        int          j;
        t = '{16'd27504, 16'd26435, -16'sd1000};
        p = '{16'd36477, -16'sd10685, 16'd3024, 16'd2855, 16'd140, -16'sd7,
              16'd15500, -16'sd14600, 16'd6000};
        h1 = 8'd75; h2 = 16'd362; h3 = 8'd0; h4 = 12'd313; h5 = 12'd50; h6 = 8'd30;
        j = (mode == 3) ? 1 : 0;
        if (mode == 3) begin
            foreach (t[i]) t[i] = t[i] + $urandom_range(64) - 32;
            foreach (p[i]) p[i] = p[i] + $urandom_range(64) - 32;
            h1 = $urandom; h3 = $urandom; h6 = $urandom_range(60);
            h2 = 16'd362 + $urandom_range(40); h4 = 12'd313 + $urandom_range(20);
            h5 = $urandom_range(60);
        end
        if (mode == 2) p[0] = '0;
        if (mode == 1 || mode == 4) begin
            write_reg(esc_pkg::REG_TEMP_CAL,       (mode == 1) ? '1 : {$urandom, $urandom});
            write_reg(esc_pkg::REG_PRESS_CAL_LO,   (mode == 1) ? '1 : {$urandom, $urandom});
            write_reg(esc_pkg::REG_PRESS_CAL_HI,   (mode == 1) ? '1 : {$urandom, $urandom});
            write_reg(esc_pkg::REG_PRESS_CAL_NINE, (mode == 1) ? '1 : {$urandom, $urandom});
            write_reg(esc_pkg::REG_HUM_CAL_LO,     (mode == 1) ? '1 : {$urandom, $urandom});
            write_reg(esc_pkg::REG_HUM_CAL_HI,     (mode == 1) ? '1 : {$urandom, $urandom});
        end else begin
            write_reg(esc_pkg::REG_TEMP_CAL,       {16'b0, t[2], t[1], t[0]});
            write_reg(esc_pkg::REG_PRESS_CAL_LO,   {p[3], p[2], p[1], p[0]});
            write_reg(esc_pkg::REG_PRESS_CAL_HI,   {p[7], p[6], p[5], p[4]});
            write_reg(esc_pkg::REG_PRESS_CAL_NINE, {48'b0, p[8]});
            write_reg(esc_pkg::REG_HUM_CAL_LO,     {24'b0, h6, h3, h2, h1});
            write_reg(esc_pkg::REG_HUM_CAL_HI,     {40'b0, h5, h4});
        end
        end_writes();
    endtask

    task automatic send_corners();
        send_sample(esc_pkg::KIND_TEMP, 20'd519888);
        send_sample(esc_pkg::KIND_PRESS, 20'd415148);
        send_sample(esc_pkg::KIND_HUM, 20'd30000);
        send_sample(esc_pkg::KIND_TEMP, '1);
        send_sample(esc_pkg::KIND_PRESS, '0);
        send_sample(esc_pkg::KIND_HUM, '1);
        send_sample(esc_pkg::KIND_TEMP, '0);
        send_sample(esc_pkg::KIND_PRESS, '1);
        send_sample(esc_pkg::KIND_HUM, '0);
    endtask

    task automatic send_random();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) send_sample(esc_pkg::KIND_TEMP, 20'd480000 + $urandom_range(80000));
        else if (sel < 55) send_sample(esc_pkg::KIND_PRESS, 20'd250000 + $urandom_range(300000));
        else if (sel < 80) send_sample(esc_pkg::KIND_HUM, 20'd15000 + $urandom_range(40000));
        else send_sample($urandom_range(3), $urandom);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        tx_idle_pct = 30; rx_idle_pct = 67; hold_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset calibration, then typical, then all ones
        send_corners();
        send_sample(KIND_UNUSED, 20'h5A5A5);
        drain();
        load_cal(0);
        send_corners();
        drain();
        load_cal(1);
        send_corners();
        send_sample(KIND_UNUSED, '1);
        drain();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        end_writes();

        for (int ph = 0; ph < 12; ph++) begin
            tx_idle_pct = (ph < 4) ? 30 : (ph < 8) ? 67 : 0;
            rx_idle_pct = (ph < 4) ? 67 : (ph < 8) ? 30 : 0;
            if (ph == 2) load_cal(2);
            else if (ph == 9) load_cal(1);
            else load_cal(($urandom_range(3) == 0) ? 4 : (ph % 2) * 3);
            if (ph == 5) hold_left = 500;
            for (int n = 0; n < 50; n++) begin
                if (ph == 6 && n == 25) begin
                    drain();
                end
                send_random();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
